[hdl/sphere_collision_resolver_core_macros.svh]
// ----------------------------------------------------------------------------
// sphere_collision_resolver_core_macros
// Assertion shorthands for the sphere collision resolver, clocked on clk and
// held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SPHERE_COLLISION_RESOLVER_CORE_MACROS_SVH
`define SPHERE_COLLISION_RESOLVER_CORE_MACROS_SVH

// Property checked at every edge outside reset
`define SCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Trigger in one cycle implies a consequence in the next
`define SCR_ASSERT_NEXT(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (conseq)) else $error(msg);

`endif

[hdl/scr_pkg.sv]
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, constants and helpers of the sphere collision resolver.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int AXES       = 3;
  localparam int W          = 32;
  localparam int FRAC       = 16;
  localparam int WIDE_W     = 40;
  localparam int ONE_Q      = 65536;

  localparam int RADIUS_W   = 31;
  localparam int REST_W     = 17;
  localparam int SHARE_W    = 17;
  localparam int COEF_W     = 18;
  localparam int NORM_W     = 18;
  localparam int VN_W       = 34;
  localparam int DV_W       = 38;

  localparam int RADIUS_RESET = 65536;
  localparam int REST_RESET   = 65536;
  localparam int COUNT_RESET  = 64;

  // Shared arithmetic unit widths
  localparam int MUL_A_W  = 37;
  localparam int MUL_B_W  = 32;
  localparam int DIV_N_W  = 48;
  localparam int DIV_D_W  = 33;
  localparam int SQRT_W   = 64;
  localparam int ROOT_W   = 32;
  localparam int ARG_W    = 64;
  localparam int RES_W    = MUL_A_W + MUL_B_W;
  localparam int STEP_W   = 6;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [1:0] {
    REG_SPHERE_RADIUS = 2'd0,
    REG_RESTITUTION   = 2'd1,
    REG_BODY_COUNT    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    AOP_MUL  = 2'd0,
    AOP_DIV  = 2'd1,
    AOP_SQRT = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef struct packed {
    logic        [W-1:0] mass;
    logic signed [W-1:0] pos_x;
    logic signed [W-1:0] pos_y;
    logic signed [W-1:0] pos_z;
    logic signed [W-1:0] vel_x;
    logic signed [W-1:0] vel_y;
    logic signed [W-1:0] vel_z;
  } body_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RUN_INIT, ST_LIM, ST_RD_I, ST_RD_J, ST_CAP_J, ST_DIFF, ST_SQ,
    ST_SQRT, ST_TOT, ST_SH1, ST_SH2, ST_NORM, ST_PUSH_I, ST_PUSH_J, ST_POS_I,
    ST_POS_J, ST_VN_I, ST_VN_J, ST_C_I, ST_C_J, ST_DV_I, ST_DV_J, ST_VEL_I,
    ST_VEL_J, ST_WR_I, ST_WR_J, ST_NEXT, ST_OUT_RD, ST_OUT_EMIT
  } seq_state_t;

  // Magnitude of a wide signed value
  function automatic logic [WIDE_W-1:0] mag_wide(input logic signed [WIDE_W-1:0] v);
    mag_wide = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
  endfunction

  // Clamp a wide signed value to one signed word
  function automatic logic signed [W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:W-1] == '0) || (v[WIDE_W-1:W-1] == '1);
    if (fits) begin
      sat_word = v[W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_word = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

endpackage

[hdl/scr_arith.sv]
// ----------------------------------------------------------------------------
// scr_arith
// Shared bit-serial arithmetic unit: shift-add multiply (one multiplier bit a
// cycle), restoring divide (one quotient bit a cycle) and digit square root
// (one root bit a cycle). Result holds until the next start.
// ----------------------------------------------------------------------------
module scr_arith import scr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  arith_req_t         req,
  input  logic [ARG_W-1:0]   arg_a,
  input  logic [DIV_D_W-1:0] arg_b,
  output arith_stat_t        stat,
  output logic [RES_W-1:0]   result
);

  logic              active;
  logic              done;
  logic [STEP_W-1:0] cnt;
  arith_op_t         op_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_A_W-1:0] mul_hi;
  logic [MUL_B_W-1:0] mul_lo;
  logic [MUL_A_W:0]   mul_t;

  logic [DIV_D_W-1:0] div_den;
  logic [DIV_D_W-1:0] div_rem;
  logic [DIV_N_W-1:0] div_nq;
  logic [DIV_D_W:0]   div_sh;
  logic [DIV_D_W:0]   div_diff;
  logic               div_ge;

  logic [SQRT_W-1:0]   sq_x;
  logic [ROOT_W+1:0]   sq_rem;
  logic [ROOT_W-1:0]   sq_root;
  logic [ROOT_W+3:0]   sq_sh;
  logic [ROOT_W+3:0]   sq_trial;
  logic [ROOT_W+3:0]   sq_diff;
  logic                sq_ge;

  // Step logic for each operation
  always_comb begin
    mul_t    = {1'b0, mul_hi} + (mul_lo[0] ? {1'b0, mul_a} : '0);
    div_sh   = {div_rem, div_nq[DIV_N_W-1]};
    div_diff = div_sh - {1'b0, div_den};
    div_ge   = (div_sh >= {1'b0, div_den});
    sq_sh    = {sq_rem, sq_x[SQRT_W-1 -: 2]};
    sq_trial = {2'b00, sq_root, 2'b01};
    sq_diff  = sq_sh - sq_trial;
    sq_ge    = (sq_sh >= sq_trial);
  end

  // Step counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        case (req.op)
          AOP_DIV:  cnt <= STEP_W'(DIV_N_W - 1);
          AOP_SQRT: cnt <= STEP_W'(ROOT_W - 1);
          default:  cnt <= STEP_W'(MUL_B_W - 1);
        endcase
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Load operands, then advance one digit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q    <= req.op;
      mul_a   <= arg_a[MUL_A_W-1:0];
      mul_hi  <= '0;
      mul_lo  <= arg_b[MUL_B_W-1:0];
      div_den <= arg_b;
      div_rem <= '0;
      div_nq  <= arg_a[DIV_N_W-1:0];
      sq_x    <= arg_a[SQRT_W-1:0];
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (active) begin
      case (op_q)
        AOP_MUL: begin
          mul_hi <= mul_t[MUL_A_W:1];
          mul_lo <= {mul_t[0], mul_lo[MUL_B_W-1:1]};
        end
        AOP_DIV: begin
          div_rem <= div_ge ? div_diff[DIV_D_W-1:0] : div_sh[DIV_D_W-1:0];
          div_nq  <= {div_nq[DIV_N_W-2:0], div_ge};
        end
        AOP_SQRT: begin
          sq_rem  <= sq_ge ? sq_diff[ROOT_W+1:0] : sq_sh[ROOT_W+1:0];
          sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
          sq_x    <= {sq_x[SQRT_W-3:0], 2'b00};
        end
        default: ;
      endcase
    end
  end

  // Present the result of the last operation
  always_comb begin
    case (op_q)
      AOP_MUL:  result = {mul_hi, mul_lo};
      AOP_DIV:  result = RES_W'(div_nq);
      AOP_SQRT: result = RES_W'(sq_root);
      default:  result = '0;
    endcase
  end

  assign stat.busy = active;
  assign stat.done = done;

endmodule

[hdl/sphere_collision_resolver_core.sv]
// ----------------------------------------------------------------------------
// sphere_collision_resolver_core
// Sphere store with an in-place pairwise collision pass and a body readout.
// ----------------------------------------------------------------------------
// Load transaction: busy stays low. Run transaction: setup, then each pair is
// read and tested; a pair that is clearly apart leaves early, a pair that
// passes the box test is also checked by distance, and a colliding pair is
// resolved in full; the serial arithmetic unit sets how long these steps take.
// Readout: each result is taken from the registered store read port.
// Synchronous reset returns to idle and restores register defaults; the body
// store is not cleared.
`include "sphere_collision_resolver_core_macros.svh"

module sphere_collision_resolver_core import scr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [IDX_W-1:0]       body_index,
  input  logic [W-1:0]           body_mass,
  input  logic signed [W-1:0]    in_pos_x,
  input  logic signed [W-1:0]    in_pos_y,
  input  logic signed [W-1:0]    in_pos_z,
  input  logic signed [W-1:0]    in_vel_x,
  input  logic signed [W-1:0]    in_vel_y,
  input  logic signed [W-1:0]    in_vel_z,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [W-1:0]           cfg_data,
  output logic                   out_valid,
  output logic [IDX_W-1:0]       out_index,
  output logic signed [W-1:0]    out_pos_x,
  output logic signed [W-1:0]    out_pos_y,
  output logic signed [W-1:0]    out_pos_z,
  output logic signed [W-1:0]    out_vel_x,
  output logic signed [W-1:0]    out_vel_y,
  output logic signed [W-1:0]    out_vel_z,
  output logic                   last_body
);

  // Configuration registers
  logic [RADIUS_W-1:0] sphere_radius;
  logic [REST_W-1:0]   restitution_coeff;
  logic [CNT_W-1:0]    body_count;

  seq_state_t state, state_next;

  logic [IDX_W-1:0] i_idx, j_idx, o_idx;
  logic [1:0]       ax;
  logic             launched;

  body_t            mem [MAX_BODIES];
  body_t            rdata;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  body_t            wdata;
  logic             we;

  logic        [W-1:0]      ma, mb;
  logic signed [W-1:0]      pa [AXES];
  logic signed [W-1:0]      pb [AXES];
  logic signed [W-1:0]      va [AXES];
  logic signed [W-1:0]      vb [AXES];
  logic signed [W:0]        d  [AXES];
  logic signed [NORM_W-1:0] s  [AXES];
  logic [2*W-1:0]           lim, acc;
  logic [W-1:0]             center_dist;
  logic [SHARE_W-1:0]       sh1, sh2;
  logic [W-1:0]             push_i, push_j;
  logic signed [VN_W-1:0]   vn_i, vn_j;
  logic [COEF_W-1:0]        c_i, c_j;
  logic signed [DV_W-1:0]   dv_i, dv_j;

  arith_req_t         arith_req;
  arith_stat_t        arith_stat;
  logic [ARG_W-1:0]   arg_a;
  logic [DIV_D_W-1:0] arg_b;
  logic [RES_W-1:0]   prod;

  // Derived values
  logic [CNT_W-1:0]        n_bodies;
  logic [W-1:0]            r2;
  logic [REST_W-1:0]       e_clamped;
  logic [COEF_W-1:0]       k_coef;
  logic [W:0]              tot;
  logic [W-1:0]            ov;
  logic signed [W:0]       d_next [AXES];
  logic                    far;
  logic [WIDE_W-1:0]       d_mag, s_mag;
  logic                    d_neg, s_neg;
  logic signed [WIDE_W-1:0] diff_ij, diff_ji;
  logic [2*W:0]            sq_sum;
  logic [WIDE_W-1:0]       q_wide;
  logic                    term_neg;
  logic signed [WIDE_W-1:0] term;
  logic signed [W-1:0]     pa_new, pb_new, va_new, vb_new;
  logic                    last_ax, looped, compute, j_more, i_more, a_done;

  arith_op_t aop;

  // Configuration write channel
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius     <= RADIUS_W'(RADIUS_RESET);
      restitution_coeff <= REST_W'(REST_RESET);
      body_count        <= CNT_W'(COUNT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPHERE_RADIUS: sphere_radius     <= cfg_data[RADIUS_W-1:0];
        REG_RESTITUTION:   restitution_coeff <= cfg_data[REST_W-1:0];
        REG_BODY_COUNT:    body_count        <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared serial arithmetic
  scr_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (arith_req),
    .arg_a  (arg_a),
    .arg_b  (arg_b),
    .stat   (arith_stat),
    .result (prod)
  );

  assign a_done = arith_stat.done;

  // Working values for the current pair and axis
  always_comb begin
    n_bodies  = (body_count > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : body_count;
    r2        = {sphere_radius, 1'b0};
    e_clamped = (restitution_coeff > REST_W'(ONE_Q)) ? REST_W'(ONE_Q) : restitution_coeff;
    k_coef    = COEF_W'(ONE_Q) + COEF_W'(e_clamped);
    tot       = {1'b0, ma} + {1'b0, mb};
    ov        = r2 - center_dist;
    far       = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      d_next[a] = {pb[a][W-1], pb[a]} - {pa[a][W-1], pa[a]};
      if (mag_wide(WIDE_W'(d_next[a])) >= WIDE_W'(r2)) far = 1'b1;
    end
    d_mag   = mag_wide(WIDE_W'(d[ax]));
    d_neg   = d[ax][W];
    s_mag   = mag_wide(WIDE_W'(s[ax]));
    s_neg   = s[ax][NORM_W-1];
    diff_ij = WIDE_W'(vn_j) - WIDE_W'(vn_i);
    diff_ji = WIDE_W'(vn_i) - WIDE_W'(vn_j);
    sq_sum  = {1'b0, acc} + {1'b0, prod[2*W-1:0]};
    q_wide  = {1'b0, prod[FRAC +: WIDE_W-1]};
    case (state)
      ST_POS_I, ST_POS_J: term_neg = s_neg;
      ST_VN_I:            term_neg = va[ax][W-1] ^ s_neg;
      ST_VN_J:            term_neg = vb[ax][W-1] ^ s_neg;
      ST_DV_I:            term_neg = diff_ij[WIDE_W-1];
      ST_DV_J:            term_neg = diff_ji[WIDE_W-1];
      ST_VEL_I:           term_neg = dv_i[DV_W-1] ^ s_neg;
      ST_VEL_J:           term_neg = dv_j[DV_W-1] ^ s_neg;
      default:            term_neg = 1'b0;
    endcase
    term   = term_neg ? -$signed(q_wide) : $signed(q_wide);
    pa_new = sat_word(WIDE_W'(pa[ax]) - term);
    pb_new = sat_word(WIDE_W'(pb[ax]) + term);
    va_new = sat_word(WIDE_W'(va[ax]) + term);
    vb_new = sat_word(WIDE_W'(vb[ax]) + term);
    last_ax = (ax == 2'(AXES - 1));
    j_more  = (({1'b0, j_idx} + CNT_W'(1)) < n_bodies);
    i_more  = (({1'b0, i_idx} + CNT_W'(2)) < n_bodies);
    looped  = state inside {ST_SQ, ST_NORM, ST_POS_I, ST_POS_J, ST_VN_I, ST_VN_J,
                            ST_VEL_I, ST_VEL_J};
    compute = looped || (state inside {ST_LIM, ST_SQRT, ST_SH1, ST_SH2, ST_PUSH_I,
                                       ST_PUSH_J, ST_C_I, ST_C_J, ST_DV_I, ST_DV_J});
  end

  // Operand select for the arithmetic unit
  always_comb begin
    aop   = AOP_MUL;
    arg_a = '0;
    arg_b = '0;
    case (state)
      ST_LIM:    begin arg_a = ARG_W'(r2); arg_b = DIV_D_W'(r2); end
      ST_SQ:     begin arg_a = ARG_W'(d_mag[W-1:0]); arg_b = DIV_D_W'(d_mag[W-1:0]); end
      ST_SQRT:   begin aop = AOP_SQRT; arg_a = ARG_W'(acc); end
      ST_SH1:    begin aop = AOP_DIV; arg_a = ARG_W'({ma, {FRAC{1'b0}}}); arg_b = tot; end
      ST_SH2:    begin aop = AOP_DIV; arg_a = ARG_W'({mb, {FRAC{1'b0}}}); arg_b = tot; end
      ST_NORM: begin
        aop   = AOP_DIV;
        arg_a = ARG_W'({d_mag[W-1:0], {FRAC{1'b0}}});
        arg_b = {1'b0, center_dist};
      end
      ST_PUSH_I: begin arg_a = ARG_W'(ov); arg_b = DIV_D_W'(sh2); end
      ST_PUSH_J: begin arg_a = ARG_W'(ov); arg_b = DIV_D_W'(sh1); end
      ST_POS_I:  begin arg_a = ARG_W'(push_i); arg_b = DIV_D_W'(s_mag[NORM_W-1:0]); end
      ST_POS_J:  begin arg_a = ARG_W'(push_j); arg_b = DIV_D_W'(s_mag[NORM_W-1:0]); end
      ST_VN_I: begin
        arg_a = ARG_W'(mag_wide(WIDE_W'(va[ax])));
        arg_b = DIV_D_W'(s_mag[NORM_W-1:0]);
      end
      ST_VN_J: begin
        arg_a = ARG_W'(mag_wide(WIDE_W'(vb[ax])));
        arg_b = DIV_D_W'(s_mag[NORM_W-1:0]);
      end
      ST_C_I:    begin arg_a = ARG_W'(k_coef); arg_b = DIV_D_W'(sh2); end
      ST_C_J:    begin arg_a = ARG_W'(k_coef); arg_b = DIV_D_W'(sh1); end
      ST_DV_I:   begin arg_a = ARG_W'(mag_wide(diff_ij)); arg_b = DIV_D_W'(c_i); end
      ST_DV_J:   begin arg_a = ARG_W'(mag_wide(diff_ji)); arg_b = DIV_D_W'(c_j); end
      ST_VEL_I: begin
        arg_a = ARG_W'(mag_wide(WIDE_W'(dv_i)));
        arg_b = DIV_D_W'(s_mag[NORM_W-1:0]);
      end
      ST_VEL_J: begin
        arg_a = ARG_W'(mag_wide(WIDE_W'(dv_j)));
        arg_b = DIV_D_W'(s_mag[NORM_W-1:0]);
      end
      default: ;
    endcase
    arith_req.start = compute && !launched;
    arith_req.op    = aop;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start && kind == KIND_RUN) state_next = ST_RUN_INIT;
      ST_RUN_INIT: begin
        if (n_bodies == '0) state_next = ST_IDLE;
        else if (n_bodies == CNT_W'(1)) state_next = ST_OUT_RD;
        else state_next = ST_LIM;
      end
      ST_LIM:      if (a_done) state_next = ST_RD_I;
      ST_RD_I:     state_next = ST_RD_J;
      ST_RD_J:     state_next = ST_CAP_J;
      ST_CAP_J:    state_next = ST_DIFF;
      ST_DIFF:     state_next = far ? ST_NEXT : ST_SQ;
      ST_SQ: begin
        if (a_done) begin
          if (sq_sum >= {1'b0, lim}) state_next = ST_NEXT;
          else if (last_ax) state_next = ST_SQRT;
        end
      end
      ST_SQRT:     if (a_done) state_next = (prod[W-1:0] == '0) ? ST_NEXT : ST_TOT;
      ST_TOT:      state_next = (tot == '0) ? ST_NEXT : ST_SH1;
      ST_SH1:      if (a_done) state_next = ST_SH2;
      ST_SH2:      if (a_done) state_next = ST_NORM;
      ST_NORM:     if (a_done && last_ax) state_next = ST_PUSH_I;
      ST_PUSH_I:   if (a_done) state_next = ST_PUSH_J;
      ST_PUSH_J:   if (a_done) state_next = ST_POS_I;
      ST_POS_I:    if (a_done && last_ax) state_next = ST_POS_J;
      ST_POS_J:    if (a_done && last_ax) state_next = ST_VN_I;
      ST_VN_I:     if (a_done && last_ax) state_next = ST_VN_J;
      ST_VN_J:     if (a_done && last_ax) state_next = ST_C_I;
      ST_C_I:      if (a_done) state_next = ST_C_J;
      ST_C_J:      if (a_done) state_next = ST_DV_I;
      ST_DV_I:     if (a_done) state_next = ST_DV_J;
      ST_DV_J:     if (a_done) state_next = ST_VEL_I;
      ST_VEL_I:    if (a_done && last_ax) state_next = ST_VEL_J;
      ST_VEL_J:    if (a_done && last_ax) state_next = ST_WR_I;
      ST_WR_I:     state_next = ST_WR_J;
      ST_WR_J:     state_next = ST_NEXT;
      ST_NEXT:     state_next = (j_more || i_more) ? ST_RD_I : ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_EMIT;
      ST_OUT_EMIT: state_next = last_body ? ST_IDLE : ST_OUT_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT_EMIT);

  // Store port select
  always_comb begin
    case (state)
      ST_RD_J:   raddr = j_idx;
      ST_OUT_RD: raddr = o_idx;
      default:   raddr = i_idx;
    endcase
    we    = 1'b0;
    waddr = body_index;
    wdata = '{mass: body_mass, pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
              vel_x: in_vel_x, vel_y: in_vel_y, vel_z: in_vel_z};
    case (state)
      ST_IDLE: we = start && kind == KIND_LOAD;
      ST_WR_I: begin
        we    = 1'b1;
        waddr = i_idx;
        wdata = '{mass: ma, pos_x: pa[0], pos_y: pa[1], pos_z: pa[2],
                  vel_x: va[0], vel_y: va[1], vel_z: va[2]};
      end
      ST_WR_J: begin
        we    = 1'b1;
        waddr = j_idx;
        wdata = '{mass: mb, pos_x: pb[0], pos_y: pb[1], pos_z: pb[2],
                  vel_x: vb[0], vel_y: vb[1], vel_z: vb[2]};
      end
      default: ;
    endcase
  end

  // Body store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Pair counters and arithmetic handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx    <= '0;
      j_idx    <= '0;
      o_idx    <= '0;
      ax       <= '0;
      launched <= 1'b0;
    end else begin
      if (arith_req.start) launched <= 1'b1;
      else if (a_done) launched <= 1'b0;
      if (looped && a_done) ax <= last_ax ? 2'd0 : ax + 2'd1;
      case (state)
        ST_IDLE: begin
          if (start && kind == KIND_RUN) begin
            i_idx <= '0;
            j_idx <= IDX_W'(1);
            o_idx <= '0;
            ax    <= '0;
          end
        end
        ST_NEXT: begin
          ax <= '0;
          if (j_more) begin
            j_idx <= j_idx + IDX_W'(1);
          end else if (i_more) begin
            i_idx <= i_idx + IDX_W'(1);
            j_idx <= i_idx + IDX_W'(2);
          end
        end
        ST_OUT_EMIT: o_idx <= o_idx + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // Pair datapath: capture operands and unit results
  always_ff @(posedge clk) begin
    case (state)
      ST_LIM: if (a_done) lim <= prod[2*W-1:0];
      ST_RD_J: begin
        ma    <= rdata.mass;
        pa[0] <= rdata.pos_x; pa[1] <= rdata.pos_y; pa[2] <= rdata.pos_z;
        va[0] <= rdata.vel_x; va[1] <= rdata.vel_y; va[2] <= rdata.vel_z;
      end
      ST_CAP_J: begin
        mb    <= rdata.mass;
        pb[0] <= rdata.pos_x; pb[1] <= rdata.pos_y; pb[2] <= rdata.pos_z;
        vb[0] <= rdata.vel_x; vb[1] <= rdata.vel_y; vb[2] <= rdata.vel_z;
      end
      ST_DIFF: begin
        for (int a = 0; a < AXES; a++) d[a] <= d_next[a];
        acc <= '0;
      end
      ST_SQ:   if (a_done) acc <= sq_sum[2*W-1:0];
      ST_SQRT: if (a_done) center_dist <= prod[W-1:0];
      ST_SH1:  if (a_done) sh1 <= prod[SHARE_W-1:0];
      ST_SH2:  if (a_done) sh2 <= prod[SHARE_W-1:0];
      ST_NORM: begin
        if (a_done) begin
          s[ax] <= d_neg ? -$signed({1'b0, prod[SHARE_W-1:0]})
                         : $signed({1'b0, prod[SHARE_W-1:0]});
        end
      end
      ST_PUSH_I: begin
        if (a_done) push_i <= prod[FRAC +: W];
        vn_i <= '0;
        vn_j <= '0;
      end
      ST_PUSH_J: if (a_done) push_j <= prod[FRAC +: W];
      ST_POS_I:  if (a_done) pa[ax] <= pa_new;
      ST_POS_J:  if (a_done) pb[ax] <= pb_new;
      ST_VN_I:   if (a_done) vn_i <= vn_i + term[VN_W-1:0];
      ST_VN_J:   if (a_done) vn_j <= vn_j + term[VN_W-1:0];
      ST_C_I:    if (a_done) c_i <= prod[FRAC +: COEF_W];
      ST_C_J:    if (a_done) c_j <= prod[FRAC +: COEF_W];
      ST_DV_I:   if (a_done) dv_i <= term[DV_W-1:0];
      ST_DV_J:   if (a_done) dv_j <= term[DV_W-1:0];
      ST_VEL_I:  if (a_done) va[ax] <= va_new;
      ST_VEL_J:  if (a_done) vb[ax] <= vb_new;
      default: ;
    endcase
  end

  // Result ports
  assign out_index = o_idx;
  assign out_pos_x = rdata.pos_x;
  assign out_pos_y = rdata.pos_y;
  assign out_pos_z = rdata.pos_z;
  assign out_vel_x = rdata.vel_x;
  assign out_vel_y = rdata.vel_y;
  assign out_vel_z = rdata.vel_z;
  assign last_body = (({1'b0, o_idx} + CNT_W'(1)) == n_bodies);

  // Checks
  `SCR_ASSERT(a_emit_busy, out_valid |-> busy, "result strobe outside a run")
  `SCR_ASSERT(a_arith_free, arith_req.start |-> !arith_stat.busy, "arith start while busy")
  `SCR_ASSERT_NEXT(a_emit_gap, out_valid && !last_body, !out_valid, "back-to-back strobe")
  `SCR_ASSERT_NEXT(a_load_idle, start && !busy && kind == KIND_LOAD, !busy, "load left idle")

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sphere_collision_resolver_core. Loads bodies, runs
// collision passes under several radius, restitution and body count settings,
// and checks every streamed body against a bit-exact fixed-point predictor or typed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scr_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [W-1:0]      mass;
    logic signed [W-1:0] px, py, pz, vx, vy, vz;
  } body_item_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic signed [W-1:0] px, py, pz, vx, vy, vz;
    logic              last;
  } body_result_t;

  typedef struct {
    bit           is_cfg;
    logic [1:0]   cfg_idx;
    logic [W-1:0] cfg_val;
    body_item_t   item;
    bit           typed;
    body_result_t exp;
  } stim_row_t;

  logic clk, rst, start, busy, kind;
  logic [IDX_W-1:0] body_index;
  logic [W-1:0] body_mass;
  logic signed [W-1:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [W-1:0] cfg_data;
  logic out_valid, last_body;
  logic [IDX_W-1:0] out_index;
  logic signed [W-1:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;

  sphere_collision_resolver_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .body_index(body_index), .body_mass(body_mass),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_index(out_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .last_body(last_body)
  );

  // Predictor state: body stores and register copies
  logic [W-1:0] mass_mem [MAX_BODIES];
  longint       pos_mem  [3][MAX_BODIES];
  longint       vel_mem  [3][MAX_BODIES];
  logic [RADIUS_W-1:0] radius_q;
  logic [REST_W-1:0]   rest_q;
  logic [CNT_W-1:0]    count_q;

  body_result_t expected_bodies[$];
  int  mismatches;
  int  items_sent;
  bit  no_gaps;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Fixed-point helpers of the predictor
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) / 65536;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Resolve one pair in place: separate along the normal, apply the impulse
  task automatic collide_pair(int i, int j, longint unsigned r2, longint unsigned lim,
                              longint k);
    longint d[3], s[3], vi[3], vj[3];
    longint unsigned acc, center_dist, m1, m2, tot, sh1, sh2, ov, mg;
    longint push_i, push_j, vni, vnj, ci, cj, dvi, dvj;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      d[a] = pos_mem[a][j] - pos_mem[a][i];
      mg = d[a] < 0 ? -d[a] : d[a];
      if (mg >= r2) return;
      if (mg * mg >= lim - acc) return;
      acc += mg * mg;
    end
    center_dist = floor_sqrt(acc);
    if (center_dist == 0) return;
    m1 = mass_mem[i];
    m2 = mass_mem[j];
    tot = m1 + m2;
    if (tot == 0) return;
    sh1 = (m1 << 16) / tot;
    sh2 = (m2 << 16) / tot;
    for (int a = 0; a < 3; a++) s[a] = (d[a] * 65536) / signed'(center_dist);
    ov = r2 - center_dist;
    push_i = signed'((ov * sh2) >> 16);
    push_j = signed'((ov * sh1) >> 16);
    for (int a = 0; a < 3; a++) begin
      pos_mem[a][i] = clamp32(pos_mem[a][i] - fx_mul(s[a], push_i));
      pos_mem[a][j] = clamp32(pos_mem[a][j] + fx_mul(s[a], push_j));
      vi[a] = vel_mem[a][i];
      vj[a] = vel_mem[a][j];
    end
    vni = fx_mul(vi[0], s[0]) + fx_mul(vi[1], s[1]) + fx_mul(vi[2], s[2]);
    vnj = fx_mul(vj[0], s[0]) + fx_mul(vj[1], s[1]) + fx_mul(vj[2], s[2]);
    ci = fx_mul(k, signed'(sh2));
    cj = fx_mul(k, signed'(sh1));
    dvi = fx_mul(vnj - vni, ci);
    dvj = fx_mul(vni - vnj, cj);
    for (int a = 0; a < 3; a++) begin
      vel_mem[a][i] = clamp32(vi[a] + fx_mul(dvi, s[a]));
      vel_mem[a][j] = clamp32(vj[a] + fx_mul(dvj, s[a]));
    end
  endtask

  // Apply one accepted transaction; a run queues the streamed bodies
  task automatic predict_bodies(body_item_t it, bit typed, body_result_t exp);
    int n;
    longint unsigned r2;
    body_result_t res;
    if (it.kind == KIND_LOAD) begin
      mass_mem[it.idx]   = it.mass;
      pos_mem[0][it.idx] = it.px;
      pos_mem[1][it.idx] = it.py;
      pos_mem[2][it.idx] = it.pz;
      vel_mem[0][it.idx] = it.vx;
      vel_mem[1][it.idx] = it.vy;
      vel_mem[2][it.idx] = it.vz;
      return;
    end
    n = count_q > MAX_BODIES ? MAX_BODIES : int'(count_q);
    r2 = 2 * longint'(radius_q);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        collide_pair(i, j, r2, r2 * r2, 65536 + (rest_q > ONE_Q ? ONE_Q : longint'(rest_q)));
    if (typed) begin
      expected_bodies.push_back(exp);
      return;
    end
    for (int i = 0; i < n; i++) begin
      res.idx = IDX_W'(i);
      res.px = W'(pos_mem[0][i]); res.py = W'(pos_mem[1][i]); res.pz = W'(pos_mem[2][i]);
      res.vx = W'(vel_mem[0][i]); res.vy = W'(vel_mem[1][i]); res.vz = W'(vel_mem[2][i]);
      res.last = (i + 1 == n);
      expected_bodies.push_back(res);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Check each streamed body against the oldest expectation
  always @(posedge clk) begin
    body_result_t e;
    if (!rst && out_valid) begin
      if (expected_bodies.size() == 0) begin
        report_mismatch($sformatf("unexpected body %0d", out_index));
      end else begin
        e = expected_bodies.pop_front();
        if (out_index !== e.idx)
          report_mismatch($sformatf("index %0d exp %0d", out_index, e.idx));
        if (out_pos_x !== e.px)
          report_mismatch($sformatf("body %0d pos_x %h exp %h", e.idx, out_pos_x, e.px));
        if (out_pos_y !== e.py)
          report_mismatch($sformatf("body %0d pos_y %h exp %h", e.idx, out_pos_y, e.py));
        if (out_pos_z !== e.pz)
          report_mismatch($sformatf("body %0d pos_z %h exp %h", e.idx, out_pos_z, e.pz));
        if (out_vel_x !== e.vx)
          report_mismatch($sformatf("body %0d vel_x %h exp %h", e.idx, out_vel_x, e.vx));
        if (out_vel_y !== e.vy)
          report_mismatch($sformatf("body %0d vel_y %h exp %h", e.idx, out_vel_y, e.vy));
        if (out_vel_z !== e.vz)
          report_mismatch($sformatf("body %0d vel_z %h exp %h", e.idx, out_vel_z, e.vz));
        if (last_body !== e.last)
          report_mismatch($sformatf("body %0d last %b exp %b", e.idx, last_body, e.last));
      end
    end
  end

  // Hold start low for a random gap, mostly short
  task automatic idle_gap();
    int r, g;
    r = $urandom_range(0, 99);
    g = no_gaps ? 0 : (r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)));
    start = 1'b0;
    repeat (g) @(negedge clk);
  endtask

  // Drive one transaction from a falling edge until accepted
  task automatic send_item(body_item_t it, bit typed, body_result_t exp);
    start = 1'b1; kind = it.kind; body_index = it.idx; body_mass = it.mass;
    in_pos_x = it.px; in_pos_y = it.py; in_pos_z = it.pz;
    in_vel_x = it.vx; in_vel_y = it.vy; in_vel_z = it.vz;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_bodies(it, typed, exp);
    items_sent++;
    @(negedge clk);
    idle_gap();
  endtask

  // Drain all results, let the block settle, then write one register
  task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
    while (expected_bodies.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_SPHERE_RADIUS: radius_q = val[RADIUS_W-1:0];
      REG_RESTITUTION:   rest_q   = val[REST_W-1:0];
      REG_BODY_COUNT:    count_q  = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [W-1:0] near_value(longint spread);
    return W'(longint'($urandom_range(0, 32'(2 * spread))) - spread);
  endfunction

  // Random body: mostly clustered within reach of each other, some noise
  function automatic body_item_t rand_body(logic [IDX_W-1:0] idx, bit noise);
    body_item_t it;
    longint spread;
    spread = radius_q > 32'h4000_0000 ? 64'h4000_0000 : (radius_q == 0 ? 64'h10000 : radius_q);
    it.kind = KIND_LOAD;
    it.idx = idx;
    if (noise || radius_q >= 32'h4000_0000) begin
      it.mass = $urandom();
      it.px = $urandom(); it.py = $urandom(); it.pz = $urandom();
      it.vx = $urandom(); it.vy = $urandom(); it.vz = $urandom();
    end else begin
      it.mass = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 32'h0010_0000);
      it.px = near_value(spread); it.py = near_value(spread); it.pz = near_value(spread);
      it.vx = near_value(64'h10_0000); it.vy = near_value(64'h10_0000);
      it.vz = near_value(64'h10_0000);
    end
    return it;
  endfunction

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    body_item_t it, run_it;
    body_result_t none;
    int n;
    none = '{default: '0};
    run_it = '{kind: KIND_RUN, idx: '1, mass: '1, px: '1, py: '1, pz: '1,
               vx: '1, vy: '1, vz: '1};
    mismatches = 0; items_sent = 0; no_gaps = 0;
    radius_q = RADIUS_RESET; rest_q = REST_RESET; count_q = COUNT_RESET;
    rst = 1'b1; start = 1'b0; kind = KIND_LOAD; body_index = '0; body_mass = '0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0; in_vel_x = '0; in_vel_y = '0; in_vel_z = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed table: single-body readout, empty run, ignored register,
    // zero radius, restitution above one, coincident centers, zero mass,
    // heavy bodies with no bounce, huge radius with saturation
    rows.push_back('{1, REG_BODY_COUNT, 1, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                     32'h8000_0000, 32'h7FFF_FFFF, 1}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 1, '{0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                     32'h8000_0000, 32'h7FFF_FFFF, 1, 1}});
    rows.push_back('{1, REG_BODY_COUNT, 0, run_it, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{1, REG_UNUSED, 32'hFFFF_FFFF, run_it, 0, none});
    rows.push_back('{1, REG_SPHERE_RADIUS, 0, run_it, 0, none});
    rows.push_back('{1, REG_BODY_COUNT, 2, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h100, 0, 0, 0}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{1, REG_SPHERE_RADIUS, 32'h0001_0000, run_it, 0, none});
    rows.push_back('{1, REG_RESTITUTION, 32'h0001_FFFF, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 0, 32'h0001_0000, 0, 0, 0, 32'h1_0000, 0, 0}, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 1, 32'h0002_0000, 32'h8000, 32'h4000, 0,
                     -32'sh1_0000, 0, 32'h1000}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 1, 32'h0002_0000, 0, 0, 0, 5, 6, 7}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 0, 0, 0, 0, 0, 1, 2, 3}, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 1, 0, 32'h1_0000, 0, 0, 4, 5, 6}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{1, REG_RESTITUTION, 0, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 1, 32'hFFFF_FFFF, 32'h1_8000, 32'h8000, 0,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});
    rows.push_back('{1, REG_SPHERE_RADIUS, 32'h7FFF_FFFF, run_it, 0, none});
    rows.push_back('{1, REG_BODY_COUNT, 3, run_it, 0, none});
    rows.push_back('{0, 0, 0, '{KIND_LOAD, 2, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, none});
    rows.push_back('{0, 0, 0, run_it, 0, none});

    foreach (rows[r]) begin
      if (rows[r].is_cfg) write_reg(rows[r].cfg_idx, rows[r].cfg_val);
      else send_item(rows[r].item, rows[r].typed, rows[r].exp);
    end

    // Fill every slot with well-separated bodies and run the full count
    write_reg(REG_SPHERE_RADIUS, 32'h0001_0000);
    write_reg(REG_RESTITUTION, REST_RESET);
    write_reg(REG_BODY_COUNT, 127);
    no_gaps = 1;
    for (int s = 0; s < MAX_BODIES; s++) begin
      it = rand_body(IDX_W'(s), 0);
      it.px = W'(s * 32'h0004_0000);
      send_item(it, 0, none);
    end
    no_gaps = 0;
    send_item(run_it, 0, none);

    // Random phases: new settings, clustered loads plus noise, then a run
    while (items_sent < 420) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 10) : $urandom_range(2, 6);
      case ($urandom_range(0, 9))
        0: write_reg(REG_SPHERE_RADIUS, 0);
        1: write_reg(REG_SPHERE_RADIUS, $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom());
        default: write_reg(REG_SPHERE_RADIUS, $urandom_range(32'h8000, 32'h3_0000));
      endcase
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_RESTITUTION,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h1_0000));
      if (radius_q >= 32'h4000_0000 && n > 3) n = 3;
      write_reg(REG_BODY_COUNT, n);
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
      no_gaps = $urandom_range(0, 4) == 0;
      for (int s = 0; s < n; s++)
        send_item(rand_body(IDX_W'(s), $urandom_range(0, 6) == 0), 0, none);
      repeat ($urandom_range(0, 2))
        send_item(rand_body(IDX_W'($urandom_range(n, MAX_BODIES - 1)), 1), 0, none);
      it = rand_body('0, 1);
      it.kind = KIND_RUN;
      send_item(it, 0, none);
      // Now and then, hold off until the whole readout has come back
      if ($urandom_range(0, 3) == 0)
        while (expected_bodies.size() != 0) @(negedge clk);
    end

    while (expected_bodies.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
